[rtl/hashed_page_table_insert_assert.svh]
// Assertion macros for the hashed page table insert block.
// Expects clk and rst_n in the scope of the including module.
`ifndef HASHED_PAGE_TABLE_INSERT_ASSERT_SVH
`define HASHED_PAGE_TABLE_INSERT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HPTI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HPTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hpti_pkg.sv]
// Package for the hashed page table insert block: field widths, hash
// constants, register indexes and the control state type. No dependencies.
`default_nettype none

package hpti_pkg;

  localparam int unsigned VA_W    = 64;
  localparam int unsigned PA_W    = 64;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned HFLAG_W = 7;
  localparam int unsigned LFLAG_W = 12;
  localparam int unsigned SLOT_W  = 27;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned MASK_W  = 24;
  localparam int unsigned CNT_W   = 4;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 160;

  // Hash and entry word layout
  localparam int unsigned HASH_HIGH_SHIFT = 28;
  localparam int unsigned AVPN_SHIFT      = 23;
  localparam logic [CNT_W-1:0] GROUP_SLOTS = 4'd8;

  localparam logic [MASK_W-1:0] GROUP_MASK_RST = 24'd2047;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_GROUP_MASK = 1'b0;
  localparam cfg_idx_t REG_SPACE_ID   = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // Even slots first: 0,2,4,6,1,3,5,7
  function automatic logic [2:0] slot_of(input logic [CNT_W-1:0] cnt);
    return {cnt[1:0], cnt[2]};
  endfunction

endpackage

`default_nettype wire

[rtl/hashed_page_table_insert.sv]
// Hashed page table insert: primary hash, fill counters indexed by the
// low group bits in one synchronous memory, read-modify-write with
// forwarding. Uses hpti_pkg. Requests are registered in stage 1, then
// in the output register. Throughput: one request per cycle unless
// out_tready stalls. Reset: synchronous, active low; then a clearing
// pass zeroes the counters, with in_tready low; config writes still taken.
`default_nettype none
`include "hashed_page_table_insert_assert.svh"

module hashed_page_table_insert #(
  parameter int unsigned FILL_ENTRIES = 2048
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // in_tdata: virt_addr[63:0], phys_addr[127:64], page_shift[132:128],
  //           high_flags[139:133], low_flags[151:140]
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [hpti_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata: written[0], slot_index[27:1], entry_high[91:28],
  //            entry_low[155:92], zero[159:156]
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [hpti_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire                               cfg_wr_en,
  input  wire  hpti_pkg::cfg_idx_t          cfg_addr,
  input  wire  [hpti_pkg::MASK_W-1:0]       cfg_wdata
);
  import hpti_pkg::*;

  localparam int unsigned FILL_AW = $clog2(FILL_ENTRIES);
  localparam logic [FILL_AW-1:0] CLR_LAST = FILL_AW'(FILL_ENTRIES - 1);

  // Input fields
  logic [VA_W-1:0]    virt_addr;
  logic [PA_W-1:0]    phys_addr;
  logic [SHIFT_W-1:0] page_shift;
  logic [HFLAG_W-1:0] high_flags;
  logic [LFLAG_W-1:0] low_flags;

  assign virt_addr  = in_tdata[63:0];
  assign phys_addr  = in_tdata[127:64];
  assign page_shift = in_tdata[132:128];
  assign high_flags = in_tdata[139:133];
  assign low_flags  = in_tdata[151:140];

  // Control state
  state_t              state_r, state_nxt;
  logic [FILL_AW-1:0]  clr_cnt_r;
  logic                clearing;
  logic [MASK_W-1:0]   group_mask_r;

  // Pipeline
  logic                s1_vld_r, s1_vld_nxt;
  logic                s1_adv;
  logic                in_fire;
  logic [MASK_W-1:0]   s1_group_r;
  logic [FILL_AW-1:0]  s1_idx_r;
  logic [ENTRY_W-1:0]  s1_ehi_r;
  logic [ENTRY_W-1:0]  s1_elo_r;

  // Counter memory and forwarding
  logic [CNT_W-1:0]    fill_mem [FILL_ENTRIES];
  logic [CNT_W-1:0]    rd_data_r;
  logic                mem_we;
  logic [FILL_AW-1:0]  mem_wa;
  logic [CNT_W-1:0]    mem_wd;
  logic                wr_vld_r;
  logic [FILL_AW-1:0]  wr_addr_r;
  logic [CNT_W-1:0]    wr_data_r;

  // Stage 0 datapath
  logic [HASH_HIGH_SHIFT-1:0] hash_lo;
  logic [MASK_W-1:0]          in_group;
  logic [FILL_AW-1:0]         in_idx;
  logic [ENTRY_W-1:0]         in_ehi;
  logic [ENTRY_W-1:0]         in_elo;

  // Stage 1 datapath
  logic [CNT_W-1:0]   cnt;
  logic               full;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [SLOT_W-1:0]  s1_slot_index;

  // Output register
  logic               out_vld_r;
  logic               out_written_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [ENTRY_W-1:0] out_ehi_r;
  logic [ENTRY_W-1:0] out_elo_r;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + FILL_AW'(1);
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_mask_r <= GROUP_MASK_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GROUP_MASK: group_mask_r <= cfg_wdata;
        REG_SPACE_ID:   ; // space id does not affect results
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !clearing && (!s1_vld_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    priority if (in_fire) s1_vld_nxt = 1'b1;
    else if (s1_adv)      s1_vld_nxt = 1'b0;
  end

  // ---------------------------------------------------------------- stage 0
  assign hash_lo  = virt_addr[HASH_HIGH_SHIFT-1:0] >> page_shift;
  assign in_group = (virt_addr[HASH_HIGH_SHIFT +: MASK_W] ^ hash_lo[MASK_W-1:0])
                    & group_mask_r;
  assign in_idx   = in_group[FILL_AW-1:0];
  assign in_ehi   = {16'd0, virt_addr[VA_W-1:AVPN_SHIFT], high_flags};
  assign in_elo   = (phys_addr & ({PA_W{1'b1}} << page_shift))
                    | {{(PA_W-LFLAG_W){1'b0}}, low_flags};

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= s1_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_group_r <= in_group;
      s1_idx_r   <= in_idx;
      s1_ehi_r   <= in_ehi;
      s1_elo_r   <= in_elo;
    end
  end

  // ---------------------------------------------------------------- memory
  always_comb begin
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = s1_vld_r && s1_adv;
      mem_wa = s1_idx_r;
      mem_wd = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) fill_mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (in_fire) rd_data_r <= fill_mem[in_idx];
  end

  // last counter write, forwarded over the read-before-write memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else if (clearing) begin
      wr_vld_r <= 1'b0;
    end else if (mem_we) begin
      wr_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && !clearing) begin
      wr_addr_r <= mem_wa;
      wr_data_r <= mem_wd;
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign cnt     = (wr_vld_r && (wr_addr_r == s1_idx_r)) ? wr_data_r : rd_data_r;
  assign full    = (cnt >= GROUP_SLOTS);
  assign cnt_nxt = full ? cnt : cnt + CNT_W'(1);
  assign s1_slot_index = full ? '0 : {s1_group_r, slot_of(cnt)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_vld_r && s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_adv) begin
      out_written_r <= !full;
      out_slot_r    <= s1_slot_index;
      out_ehi_r     <= s1_ehi_r;
      out_elo_r     <= s1_elo_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_elo_r, out_ehi_r, out_slot_r, out_written_r};

  // ---------------------------------------------------------------- checks
  `HPTI_ASSERT_SAME(a_full_slot_zero, out_vld_r && !out_written_r, out_slot_r == '0,
    "full group result carries a nonzero slot index")
  `HPTI_ASSERT_SAME(a_cnt_sat, mem_we && !clearing, mem_wd <= GROUP_SLOTS,
    "fill counter written above group size")
  `HPTI_ASSERT_NEXT(a_clear_holds, clearing && (clr_cnt_r != CLR_LAST),
    clearing && !in_tready, "clearing pass ended early")
  `HPTI_ASSERT_NEXT(a_s1_hold, s1_vld_r && !s1_adv, s1_vld_r && $stable(s1_idx_r),
    "stalled request lost in stage 1")

endmodule

`default_nettype wire

[verif/tb_hashed_page_table_insert.sv]
// Self-checking testbench for hashed_page_table_insert: directed table plus random mapping
// requests, checked against an in-bench model of the group hash and fill counters.
// Depends on hpti_pkg and the hashed_page_table_insert RTL.
`default_nettype none

module tb_hashed_page_table_insert;
  timeunit 1ns;
  timeprecision 1ps;

  import hpti_pkg::*;

  localparam int unsigned FILL_ENTRIES = 2048;
  localparam int unsigned SPACE_W      = 16;
  localparam int unsigned AVPN_POS     = 7;
  localparam logic [63:0] HASH_HIGH_BITS = 64'h7f_ffff_ffff;
  localparam logic [63:0] HASH_LOW_BITS  = 64'h0fff_ffff;

  // lowest field last, so the struct packs straight onto the bus
  typedef struct packed {
    logic [LFLAG_W-1:0] lf;
    logic [HFLAG_W-1:0] hf;
    logic [SHIFT_W-1:0] sh;
    logic [PA_W-1:0]    pa;
    logic [VA_W-1:0]    va;
  } map_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_low;
    logic [ENTRY_W-1:0] entry_high;
    logic [SLOT_W-1:0]  slot_index;
    logic               written;
  } pte_result_t;

  typedef struct packed {
    bit          typed;
    pte_result_t want;
    map_req_t    req;
  } dir_row_t;

  typedef struct packed {
    logic [VA_W-1:0]    va;
    logic [SHIFT_W-1:0] sh;
  } hot_page_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // virt_addr, phys_addr, page_shift, high_flags, low_flags
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // written, slot_index, entry_high, entry_low, zero pad
  logic                  cfg_wr_en;
  cfg_idx_t              cfg_addr;
  logic [MASK_W-1:0]     cfg_wdata;

  logic [MASK_W-1:0]  model_mask;
  logic [SPACE_W-1:0] model_space_id;
  logic [CNT_W-1:0]   fill_cnt [FILL_ENTRIES];

  pte_result_t pending_ptes [$];
  hot_page_t   hot_pages [$];
  dir_row_t    dir_tab [$];
  bit          calm;
  int          mismatches;

  hashed_page_table_insert #(
    .FILL_ENTRIES(FILL_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("tb_hashed_page_table_insert failed");
    $finish;
  end

  function automatic pte_result_t predict_insert(input map_req_t r);
    pte_result_t res;
    logic [63:0] hash;
    logic [MASK_W-1:0] grp;
    int unsigned idx;
    logic [CNT_W-1:0] cnt;
    logic [2:0] slot;
    hash = ((r.va >> HASH_HIGH_SHIFT) & HASH_HIGH_BITS) ^ ((r.va & HASH_LOW_BITS) >> r.sh);
    grp = hash[MASK_W-1:0] & model_mask;
    idx = grp % FILL_ENTRIES;
    cnt = fill_cnt[idx];
    res.entry_high = ((r.va >> AVPN_SHIFT) << AVPN_POS) | ENTRY_W'(r.hf);
    res.entry_low  = (r.pa & ~((64'd1 << r.sh) - 64'd1)) | ENTRY_W'(r.lf);
    if (cnt >= GROUP_SLOTS) begin
      res.written    = 1'b0;
      res.slot_index = '0;
    end else begin
      fill_cnt[idx] = cnt + 1'b1;
      // even slots first
      slot = {cnt[1:0], 1'b0} | {2'b00, cnt[2]};
      res.written    = 1'b1;
      res.slot_index = {grp, slot};
    end
    return res;
  endfunction

  function automatic dir_row_t mk(input logic [63:0] va, input logic [63:0] pa,
                                  input logic [4:0] sh, input logic [6:0] hf,
                                  input logic [11:0] lf, input bit typed,
                                  input logic w, input logic [26:0] slot,
                                  input logic [63:0] eh, input logic [63:0] el);
    dir_row_t row;
    row.req   = '{lf: lf, hf: hf, sh: sh, pa: pa, va: va};
    row.typed = typed;
    row.want  = '{entry_low: el, entry_high: eh, slot_index: slot, written: w};
    return row;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [MASK_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_GROUP_MASK) model_mask = val;
    else model_space_id = val[SPACE_W-1:0];
  endtask

  task automatic set_config(input logic [MASK_W-1:0] mask, input logic [SPACE_W-1:0] sid);
    write_reg(REG_GROUP_MASK, mask);
    write_reg(REG_SPACE_ID, MASK_W'(sid));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_req(input map_req_t r, input bit typed, input pte_result_t want);
    pte_result_t pred;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
    pred = predict_insert(r);
    pending_ptes.push_back(typed ? want : pred);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_ptes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [MASK_W-1:0] mask, input logic [SPACE_W-1:0] sid,
                           input int n, input bit alias_hi);
    hot_page_t h;
    map_req_t r;
    set_config(mask, sid);
    hot_pages.delete();
    for (int i = 0; i < 12; i++) begin
      h.va = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: h.sh = 5'd12;
        1: h.sh = 5'd24;
        2: h.sh = 5'($urandom_range(12, 28));
        default: h.sh = 5'($urandom_range(0, 31));
      endcase
      hot_pages.push_back(h);
    end
    for (int i = 0; i < n; i++) begin
      // mostly revisit hot pages so groups fill up
      if ($urandom_range(0, 9) < 7) begin
        h = hot_pages[$urandom_range(0, 11)];
        r.va = h.va;
        r.sh = h.sh;
        // flip hash bits above the counter index: new group if the mask keeps them, shared counter
        if (alias_hi && $urandom_range(0, 3) == 0) r.va ^= 64'($urandom_range(1, 8191)) << 39;
      end else begin
        r.va = {$urandom, $urandom};
        r.sh = 5'($urandom_range(0, 31));
      end
      r.pa = {$urandom, $urandom};
      r.hf = 7'($urandom);
      r.lf = 12'($urandom);
      send_req(r, 1'b0, '0);
    end
    drain();
  endtask

  // result side: checks, random stalls, two long hold-offs
  initial begin
    pte_result_t got;
    pte_result_t want;
    int results_seen;
    int hold_left;
    int stall_left;
    results_seen = 0;
    hold_left = 0;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata[$bits(pte_result_t)-1:0];
        results_seen++;
        if (results_seen == 100 || results_seen == 320) hold_left = 80;
        if (pending_ptes.size() == 0) begin
          $error("unexpected result: slot_index %0d", got.slot_index);
          mismatches++;
        end else begin
          want = pending_ptes.pop_front();
          if (got.written !== want.written) begin
            $error("written: expected %0d, actual %0d", want.written, got.written);
            mismatches++;
          end
          if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
            mismatches++;
          end
          if (got.entry_high !== want.entry_high) begin
            $error("entry_high: expected %h, actual %h", want.entry_high, got.entry_high);
            mismatches++;
          end
          if (got.entry_low !== want.entry_low) begin
            $error("entry_low: expected %h, actual %h", want.entry_low, got.entry_low);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_addr   <= REG_GROUP_MASK;
    cfg_wdata  <= '0;
    calm       = 1'b0;
    mismatches = 0;
    model_mask = GROUP_MASK_RST;
    model_space_id = '0;
    foreach (fill_cnt[i]) fill_cnt[i] = '0;

    // default mask 2047; group 0 is driven to full
    dir_tab.push_back(mk(64'h0, 64'h0, 5'd12, 7'h00, 12'h000,
                         1, 1'b1, 27'd0, 64'h0, 64'h0));
    dir_tab.push_back(mk('1, '1, 5'd31, 7'h7f, 12'hfff,
                         1, 1'b1, 27'd16376, 64'h0000_ffff_ffff_ffff, 64'hffff_ffff_8000_0fff));
    dir_tab.push_back(mk('1, '1, 5'd0, 7'h01, 12'h001, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, 64'h0123_4567_89ab_cdef, 5'd12, 7'h40, 12'h800, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, 64'hfedc_ba98_7654_3210, 5'd24, 7'h3f, 12'h7ff, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, '1, 5'd28, 7'h00, 12'hfff, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, '1, 5'd0, 7'h7f, 12'h000, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, '1, 5'd31, 7'h12, 12'h345, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, 64'h8000_0000_0000_0001, 5'd5, 7'h21, 12'h421, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0, 64'h0, 5'd12, 7'h55, 12'haaa,
                         1, 1'b0, 27'd0, 64'h55, 64'haaa));
    dir_tab.push_back(mk(64'h0, '1, 5'd28, 7'h2a, 12'h555,
                         1, 1'b0, 27'd0, 64'h2a, 64'hffff_ffff_f000_0555));
    dir_tab.push_back(mk(64'h0100_0000, 64'h0abc_def0_1234_5678, 5'd24, 7'h08, 12'h010,
                         0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h1000_0000, 64'h1111_2222_3333_4444, 5'd12, 7'h04, 12'h020,
                         0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h1000_0000, 64'h5555_6666_7777_8888, 5'd12, 7'h02, 12'h040,
                         0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0000_0080_0000_0000, 64'h0, 5'd12, 7'h00, 12'h000,
                         1, 1'b0, 27'd0, 64'h0000_0000_0080_0000, 64'h0));
    dir_tab.push_back(mk(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd13, 7'h2a, 12'h555,
                         0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd17, 7'h55, 12'haaa,
                         0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h0000_0000_0f0f_f0f0, 64'h0f0f_0f0f_0f0f_0f0f, 5'd1, 7'h11, 12'h111,
                         0, 0, 0, 0, 0));
    dir_tab.push_back(mk(64'h8000_0000_0000_0000, 64'h1234_5678_9abc_def0, 5'd28, 7'h7f, 12'h000,
                         1, 1'b0, 27'd0, 64'h0000_8000_0000_007f, 64'h1234_5678_9000_0000));
    dir_tab.push_back(mk(64'h1000_0000, 64'h0, 5'd12, 7'h01, 12'h002, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    drain();

    run_phase(24'd0, 16'hffff, 30, 1'b0);
    run_phase(24'd7, 16'($urandom), 80, 1'b0);
    run_phase(24'hff_ffff, 16'd0, 80, 1'b1);
    run_phase(24'($urandom_range(1, 24'hff_fffe)), 16'($urandom), 80, 1'b1);
    run_phase(GROUP_MASK_RST, 16'($urandom), 90, 1'b1);
    calm = 1'b1;
    run_phase(24'd63, 16'hffff, 90, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_ptes.size() == 0) begin
      $display("tb_hashed_page_table_insert passed");
    end else begin
      $display("tb_hashed_page_table_insert failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
